// ----- src/bhfs_pkg.sv -----
`default_nettype none

package bhfs_pkg;

    localparam logic [7:0] TAG_STRING    = 8'h1a;
    localparam logic [7:0] TAG_INTEGER   = 8'h02;
    localparam logic [7:0] LONG_FORM_BIT = 8'h80;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_INT   = 2'd2;

    localparam logic [7:0] ORDINAL_MAX = 8'hff;

    typedef struct packed {
        logic       start_of_header;
        logic [7:0] header_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [7:0]         field_ordinal;
        logic signed [31:0] event_value;
        logic               field_done;
    } event_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == ORDINAL_MAX) ? ORDINAL_MAX : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

// ----- src/bhfs_core.sv -----
`default_nettype none

// Parse state machine: one header byte is handled per accepted word, and the
// event that it causes, if any, is presented in the same cycle.
module bhfs_core
    import bhfs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   fire,
    input  wire item_t  item,
    output logic        res_valid,
    output event_t      res
);

    typedef enum logic [2:0] {
        MODE_SCAN     = 3'd0,
        MODE_STR_LEN  = 3'd1,
        MODE_STR_LONG = 3'd2,
        MODE_STR_BODY = 3'd3,
        MODE_INT_LEN  = 3'd4,
        MODE_INT_BODY = 3'd5
    } mode_t;

    mode_t       mode_reg, mode_next, mode_cur;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [31:0] integer_accum_reg, integer_accum_next;
    logic [7:0]  string_count_reg, string_count_next, string_count_cur;
    logic [7:0]  integer_count_reg, integer_count_next, integer_count_cur;
    logic [7:0]  b;
    logic [31:0] long_accum;
    logic [31:0] int_accum;
    logic [31:0] left_dec;

    assign b = item.header_byte;

    always_comb
    begin
        // A start flag restarts parsing before the byte itself is looked at.
        mode_cur          = item.start_of_header ? MODE_SCAN : mode_reg;
        string_count_cur  = item.start_of_header ? 8'd0 : string_count_reg;
        integer_count_cur = item.start_of_header ? 8'd0 : integer_count_reg;

        long_accum = {length_accum_reg[23:0], b};
        int_accum  = {integer_accum_reg[23:0], b};
        left_dec   = bytes_left_reg - 32'd1;

        mode_next          = mode_cur;
        bytes_left_next    = bytes_left_reg;
        length_accum_next  = length_accum_reg;
        integer_accum_next = integer_accum_reg;
        string_count_next  = string_count_cur;
        integer_count_next = integer_count_cur;
        res_valid          = 1'b0;
        res.event_kind     = KIND_EMPTY;
        res.field_ordinal  = string_count_cur;
        res.event_value    = '0;
        res.field_done     = 1'b1;

        case (mode_cur)
            MODE_STR_LEN:
            begin
                if ((b & LONG_FORM_BIT) != 8'd0)
                begin
                    length_accum_next = '0;
                    bytes_left_next   = {25'd0, b[6:0]};
                    if (b[6:0] == 7'd0)
                    begin
                        res_valid         = 1'b1;
                        string_count_next = sat_inc(string_count_cur);
                        mode_next         = MODE_SCAN;
                    end
                    else
                    begin
                        mode_next = MODE_STR_LONG;
                    end
                end
                else if (b == 8'd0)
                begin
                    res_valid         = 1'b1;
                    string_count_next = sat_inc(string_count_cur);
                    mode_next         = MODE_SCAN;
                end
                else
                begin
                    bytes_left_next = {24'd0, b};
                    mode_next       = MODE_STR_BODY;
                end
            end
            MODE_STR_LONG:
            begin
                length_accum_next = long_accum;
                bytes_left_next   = left_dec;
                if (left_dec == 32'd0)
                begin
                    if (long_accum == 32'd0)
                    begin
                        res_valid         = 1'b1;
                        string_count_next = sat_inc(string_count_cur);
                        mode_next         = MODE_SCAN;
                    end
                    else
                    begin
                        bytes_left_next = long_accum;
                        mode_next       = MODE_STR_BODY;
                    end
                end
            end
            MODE_STR_BODY:
            begin
                res_valid       = 1'b1;
                res.event_kind  = KIND_CHAR;
                res.event_value = {24'd0, b};
                res.field_done  = (bytes_left_reg <= 32'd1);
                if (bytes_left_reg <= 32'd1)
                begin
                    bytes_left_next   = '0;
                    string_count_next = sat_inc(string_count_cur);
                    mode_next         = MODE_SCAN;
                end
                else
                begin
                    bytes_left_next = left_dec;
                end
            end
            MODE_INT_LEN:
            begin
                integer_accum_next = '0;
                if (b == 8'd0)
                begin
                    res_valid          = 1'b1;
                    res.event_kind     = KIND_INT;
                    res.field_ordinal  = integer_count_cur;
                    integer_count_next = sat_inc(integer_count_cur);
                    mode_next          = MODE_SCAN;
                end
                else
                begin
                    bytes_left_next = {24'd0, b};
                    mode_next       = MODE_INT_BODY;
                end
            end
            MODE_INT_BODY:
            begin
                integer_accum_next = int_accum;
                bytes_left_next    = (bytes_left_reg == 32'd0) ? 32'd0 : left_dec;
                if (bytes_left_reg <= 32'd1)
                begin
                    res_valid          = 1'b1;
                    res.event_kind     = KIND_INT;
                    res.field_ordinal  = integer_count_cur;
                    res.event_value    = int_accum;
                    integer_count_next = sat_inc(integer_count_cur);
                    mode_next          = MODE_SCAN;
                end
            end
            default:
            begin
                if (b == TAG_STRING)
                begin
                    mode_next = MODE_STR_LEN;
                end
                else if (b == TAG_INTEGER)
                begin
                    mode_next = MODE_INT_LEN;
                end
                else
                begin
                    mode_next = MODE_SCAN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_SCAN;
            bytes_left_reg    <= '0;
            length_accum_reg  <= '0;
            integer_accum_reg <= '0;
            string_count_reg  <= '0;
            integer_count_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg          <= mode_next;
            bytes_left_reg    <= bytes_left_next;
            length_accum_reg  <= length_accum_next;
            integer_accum_reg <= integer_accum_next;
            string_count_reg  <= string_count_next;
            integer_count_reg <= integer_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/ber_header_field_scanner_unit.sv -----
`default_nettype none

// BER header field scanner. Takes one header byte per word and reports
// visible-string characters, empty strings and completed integers. A byte
// is taken in every cycle in which item_stall is low; each event is
// registered and leaves from an output register. A two-entry
// output stage (output register plus skid register) lets the input keep
// flowing while the sink stalls; item_stall rises only when
// both entries hold an event.
module ber_header_field_scanner_unit
    import bhfs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    output logic        item_stall,
    input  wire item_t  item,
    output logic        evt_valid,
    input  wire logic   evt_stall,
    output event_t      evt
);

    logic   fire;
    logic   res_valid;
    event_t res;
    logic   push;
    logic   out_free;
    logic   out_valid_reg;
    event_t out_data_reg;
    logic   skid_valid_reg;
    event_t skid_data_reg;

    assign item_stall = skid_valid_reg;
    assign fire       = item_valid && !skid_valid_reg;
    assign push       = fire && res_valid;
    assign out_free   = !out_valid_reg || !evt_stall;
    assign evt_valid  = out_valid_reg;
    assign evt        = out_data_reg;

    bhfs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // The skid word is older than any new word and goes out first.
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (push)
        begin
            skid_data_reg <= res;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !evt_stall) |=> (evt_valid && !skid_valid_reg))
        else $error("skid word not moved to output");

    a_done_on_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.event_kind != KIND_CHAR) |-> evt.field_done)
        else $error("empty string or integer event without done flag");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.event_kind == KIND_EMPTY) |-> (evt.event_value == 32'sd0))
        else $error("empty string event with nonzero value");

endmodule

`default_nettype wire
